>>> rtl/core/ast_pkg.sv
`default_nettype none

package ast_pkg;

  localparam int SEQ_DEPTH  = 16;
  localparam int LINK_DEPTH = 256;

  localparam int SEQ_AW  = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
  localparam int SEQ_CW  = $clog2(SEQ_DEPTH + 1);
  localparam int LINK_AW = (LINK_DEPTH > 1) ? $clog2(LINK_DEPTH) : 1;

  localparam logic [8:0] LEN_MAX = 9'd256;

  typedef enum logic [1:0] {
    ACT_LINK      = 2'd0,
    ACT_SEQ       = 2'd1,
    ACT_CHECK_DEC = 2'd2,
    ACT_CHECK     = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    CFG_ENABLE = 2'd0,
    CFG_AUDIT  = 2'd1,
    CFG_NSEQ   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] subject;
    logic [31:0] target;
    logic [15:0] cls;
    logic [31:0] perms;
  } link_rec_t;

  typedef struct packed {
    logic [7:0] base;
    logic [8:0] len;
    logic [7:0] pos;
  } seq_rec_t;

endpackage

`default_nettype wire

>>> rtl/core/ast_ram.sv
`default_nettype none

module ast_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/core/access_sequence_tracker_core.sv
`default_nettype none

// Channel   Handshake            Payload
// in        start / busy         in_action .. in_link_count
// out       out_valid (strobe)   out_deny, out_any_match, out_checked
// cfg       cfg_we               cfg_index, cfg_data
//
// Link and sequence writes, and checks that pass the prior decision through,
// give their result in the cycle after the start beat; busy stays low.
// A real check walks n = min(num_sequences, SEQ_DEPTH) entries, one sequence
// table read per cycle behind the single read port, with a link read and the
// compare behind it; busy holds until the result shows.
// Reset (synchronous, rst_n low) clears the configuration, the sequence
// valid bits and the control; the memories need no clearing pass.
// The receiver cannot stall: each result shows for exactly one cycle.

module access_sequence_tracker_core
  import ast_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_index,
  input  logic [31:0] in_src_sid,
  input  logic [31:0] in_tgt_sid,
  input  logic [15:0] in_obj_class,
  input  logic [31:0] in_requested,
  input  logic [31:0] in_allowed,
  input  logic [31:0] in_audit_allow,
  input  logic [31:0] in_audit_deny,
  input  logic        in_prior_deny,
  input  logic [7:0]  in_link_base,
  input  logic [8:0]  in_link_count,
  output logic        out_valid,
  output logic        out_deny,
  output logic        out_any_match,
  output logic        out_checked,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t state_r;

  // configuration
  logic       enable_r;
  logic       audit_only_r;
  logic [4:0] num_seq_r;

  // sequence entry valid bits; an invalid entry reads as length zero
  logic [SEQ_DEPTH-1:0] seq_vld_r;

  // check walk control
  logic [SEQ_CW-1:0] n_r;
  logic [SEQ_CW-1:0] rd_cnt_r;
  logic              p1_v_r;
  logic              p2_v_r;
  logic              any_r;
  logic              deny_r;

  // payload held for the walk
  logic [SEQ_AW-1:0] p1_idx_r;
  logic [SEQ_AW-1:0] p2_idx_r;
  seq_rec_t          p2_seq_r;
  logic [31:0]       acc_src_r;
  logic [31:0]       acc_tgt_r;
  logic [15:0]       acc_cls_r;
  logic [31:0]       acc_req_r;

  logic out_valid_r;
  logic out_deny_r;
  logic out_any_r;
  logic out_checked_r;

  // memory ports
  logic              seq_we;
  logic [SEQ_AW-1:0] seq_waddr;
  seq_rec_t          seq_wdata;
  seq_rec_t          seq_rd;
  logic              link_we;
  link_rec_t         link_wdata;
  logic [LINK_AW-1:0] link_raddr;
  link_rec_t         link_rd;

  logic        accept;
  act_t        act;
  logic        seq_idx_ok;
  logic        link_idx_ok;
  logic [31:0] denied_bits;
  logic        audit_miss;
  logic        pass_thru;
  logic [8:0]  len_sat;
  logic        p1_active;
  logic        p2_match;
  logic        p2_last;
  logic        p2_adv;
  logic        walk_done;

  assign accept      = start && (state_r == ST_IDLE);
  assign act         = act_t'(in_action);
  assign seq_idx_ok  = 32'(in_index) < SEQ_DEPTH;
  assign link_idx_ok = 32'(in_index) < LINK_DEPTH;
  assign len_sat     = (in_link_count > LEN_MAX) ? LEN_MAX : in_link_count;

  // Audit filter: with denied bits, look at audit_deny, else at audit_allow.
  assign denied_bits = in_requested & ~in_allowed;
  assign audit_miss  = (denied_bits != 32'd0) ? ((denied_bits & in_audit_deny) == 32'd0)
                                              : ((in_requested & in_audit_allow) == 32'd0);
  assign pass_thru   = !enable_r || ((act == ACT_CHECK_DEC) && audit_only_r && audit_miss);

  // Stage 1: sequence record is back; drop inactive entries, fetch the link.
  assign p1_active  = p1_v_r && seq_vld_r[p1_idx_r] && (seq_rd.len != 9'd0);
  assign link_raddr = LINK_AW'({1'b0, seq_rd.base} + {1'b0, seq_rd.pos});

  // Stage 2: link is back; compare against the held access.
  assign p2_match = p2_v_r &&
                    (link_rd.subject == acc_src_r) &&
                    (link_rd.target == acc_tgt_r) &&
                    (link_rd.cls == acc_cls_r) &&
                    ((link_rd.perms & acc_req_r) != 32'd0);
  assign p2_last  = ({1'b0, p2_seq_r.pos} + 9'd1) >= p2_seq_r.len;
  assign p2_adv   = p2_match && !p2_last;

  assign walk_done = (rd_cnt_r == n_r) && !p1_v_r && !p2_v_r;

  // Sequence memory write: load from a write beat, or advance a position.
  // Each entry is read once and written back at most once per walk, so no forwarding.
  always_comb begin
    seq_we    = 1'b0;
    seq_waddr = p2_idx_r;
    seq_wdata = p2_seq_r;
    if (accept && (act == ACT_SEQ) && seq_idx_ok) begin
      seq_we         = 1'b1;
      seq_waddr      = SEQ_AW'(in_index);
      seq_wdata.base = in_link_base;
      seq_wdata.len  = len_sat;
      seq_wdata.pos  = 8'd0;
    end else if (p2_adv) begin
      seq_we        = 1'b1;
      seq_wdata.pos = p2_seq_r.pos + 8'd1;
    end
  end

  assign link_we            = accept && (act == ACT_LINK) && link_idx_ok;
  assign link_wdata.subject = in_src_sid;
  assign link_wdata.target  = in_tgt_sid;
  assign link_wdata.cls     = in_obj_class;
  assign link_wdata.perms   = in_requested;

  ast_ram #(
    .WIDTH ($bits(seq_rec_t)),
    .DEPTH (SEQ_DEPTH)
  ) u_seq_ram (
    .clk   (clk),
    .we    (seq_we),
    .waddr (seq_waddr),
    .wdata (seq_wdata),
    .raddr (rd_cnt_r[SEQ_AW-1:0]),
    .rdata (seq_rd)
  );

  ast_ram #(
    .WIDTH ($bits(link_rec_t)),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (LINK_AW'(in_index)),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rd)
  );

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    p1_idx_r <= rd_cnt_r[SEQ_AW-1:0];
    p2_idx_r <= p1_idx_r;
    p2_seq_r <= seq_rd;
    if (accept) begin
      acc_src_r <= in_src_sid;
      acc_tgt_r <= in_tgt_sid;
      acc_cls_r <= in_obj_class;
      acc_req_r <= in_requested;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      enable_r      <= 1'b0;
      audit_only_r  <= 1'b0;
      num_seq_r     <= 5'd0;
      seq_vld_r     <= '0;
      n_r           <= '0;
      rd_cnt_r      <= '0;
      p1_v_r        <= 1'b0;
      p2_v_r        <= 1'b0;
      any_r         <= 1'b0;
      deny_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      out_deny_r    <= 1'b0;
      out_any_r     <= 1'b0;
      out_checked_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_ENABLE: enable_r     <= cfg_data[0];
          CFG_AUDIT:  audit_only_r <= cfg_data[0];
          CFG_NSEQ:   num_seq_r    <= cfg_data;
          default: ;
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            unique case (act)
              ACT_LINK, ACT_SEQ: begin
                out_valid_r   <= 1'b1;
                out_deny_r    <= 1'b0;
                out_any_r     <= 1'b0;
                out_checked_r <= 1'b0;
                if ((act == ACT_SEQ) && seq_idx_ok) begin
                  seq_vld_r[SEQ_AW'(in_index)] <= 1'b1;
                end
              end
              ACT_CHECK_DEC, ACT_CHECK: begin
                if (pass_thru) begin
                  out_valid_r   <= 1'b1;
                  out_deny_r    <= in_prior_deny;
                  out_any_r     <= 1'b0;
                  out_checked_r <= 1'b0;
                end else begin
                  state_r  <= ST_RUN;
                  rd_cnt_r <= '0;
                  n_r      <= (32'(num_seq_r) > SEQ_DEPTH) ? SEQ_CW'(SEQ_DEPTH)
                                                           : SEQ_CW'(num_seq_r);
                  any_r    <= 1'b0;
                  deny_r   <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_RUN: begin
          // advance the read pointer, one sequence entry per cycle
          p1_v_r <= rd_cnt_r < n_r;
          if (rd_cnt_r < n_r) begin
            rd_cnt_r <= rd_cnt_r + SEQ_CW'(1);
          end
          p2_v_r <= p1_active;
          if (p2_match) begin
            any_r <= 1'b1;
            if (p2_last) begin
              deny_r <= 1'b1;
            end
          end
          if (walk_done) begin
            out_valid_r   <= 1'b1;
            out_deny_r    <= deny_r;
            out_any_r     <= any_r;
            out_checked_r <= 1'b1;
            state_r       <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_deny      = out_deny_r;
  assign out_any_match = out_any_r;
  assign out_checked   = out_checked_r;

endmodule

`default_nettype wire

>>> rtl/core/ast_checker.sv
`default_nettype none

module ast_checker
  import ast_pkg::*;
(
  input wire        clk,
  input wire        rst_n,
  input wire        start,
  input wire        busy,
  input wire [1:0]  in_action,
  input wire        out_valid,
  input wire        out_deny,
  input wire        out_any_match,
  input wire        out_checked
);

  // a write beat answers in the next cycle with a plain allow
  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_action == ACT_LINK || in_action == ACT_SEQ))
      |=> (out_valid && !out_deny && !out_any_match && !out_checked))
    else $error("write beat without its result");

  // a check beat either answers at once or holds busy
  a_check_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_action == ACT_CHECK_DEC || in_action == ACT_CHECK))
      |=> (out_valid || busy))
    else $error("check beat dropped");

  // a match is only reported on a checked beat
  a_match_checked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_any_match) |-> out_checked)
    else $error("match without check");

  // a checked deny needs a match
  a_deny_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_checked && out_deny) |-> out_any_match)
    else $error("checked deny without match");

  // results never show while a walk is still running
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

endmodule

bind access_sequence_tracker_core ast_checker u_ast_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_action     (in_action),
  .out_valid     (out_valid),
  .out_deny      (out_deny),
  .out_any_match (out_any_match),
  .out_checked   (out_checked)
);

`default_nettype wire
